// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for concurrent assertions used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define GCRF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define GCRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/gcrf_pkg.sv =====
// ----------------------------------------------------------------------------
// gcrf_pkg
// Shared constants, codes and helper functions of the GC content block.
// ----------------------------------------------------------------------------
package gcrf_pkg;

	localparam int unsigned MAX_BASES_DEF      = 268435456;
	localparam int unsigned MAX_SITE_BASES_DEF = 16;

	localparam int unsigned NEAR_RESET = 150000;
	localparam int unsigned WIDE_RESET = 500000;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_PROBE = 2'd1,
		KIND_NEW   = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_NEAR_WINDOW = 3'd0,
		REG_WIDE_WINDOW = 3'd1,
		REG_A_PATTERN   = 3'd2,
		REG_A_LENGTH    = 3'd3,
		REG_A_CUT       = 3'd4,
		REG_B_PATTERN   = 3'd5,
		REG_B_LENGTH    = 3'd6,
		REG_B_CUT       = 3'd7
	} reg_idx_t;

	localparam logic [3:0] CODE_A    = 4'd0;
	localparam logic [3:0] CODE_C    = 4'd1;
	localparam logic [3:0] CODE_G    = 4'd2;
	localparam logic [3:0] CODE_T    = 4'd3;
	localparam logic [3:0] CODE_N    = 4'd4;
	localparam logic [3:0] CODE_R    = 4'd5;
	localparam logic [3:0] CODE_Y    = 4'd6;
	localparam logic [3:0] CODE_M    = 4'd7;
	localparam logic [3:0] CODE_S    = 4'd8;
	localparam logic [3:0] CODE_K    = 4'd9;
	localparam logic [3:0] CODE_W    = 4'd10;
	localparam logic [3:0] CODE_B    = 4'd11;
	localparam logic [3:0] CODE_D    = 4'd12;
	localparam logic [3:0] CODE_H    = 4'd13;
	localparam logic [3:0] CODE_V    = 4'd14;
	localparam logic [3:0] CODE_NONE = 4'd15;

	// Maps a raw byte, either case, to its 4-bit base code.
	function automatic logic [3:0] char_code(input logic [7:0] ch);
		logic [7:0] up;
		up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
		unique case (up)
			8'h41:   return CODE_A;
			8'h43:   return CODE_C;
			8'h47:   return CODE_G;
			8'h54:   return CODE_T;
			8'h4E:   return CODE_N;
			8'h52:   return CODE_R;
			8'h59:   return CODE_Y;
			8'h4D:   return CODE_M;
			8'h53:   return CODE_S;
			8'h4B:   return CODE_K;
			8'h57:   return CODE_W;
			8'h42:   return CODE_B;
			8'h44:   return CODE_D;
			8'h48:   return CODE_H;
			8'h56:   return CODE_V;
			default: return CODE_NONE;
		endcase
	endfunction

	function automatic logic is_gc(input logic [3:0] c);
		return (c == CODE_C) || (c == CODE_G) || (c == CODE_S);
	endfunction

	function automatic logic is_at(input logic [3:0] c);
		return (c == CODE_A) || (c == CODE_T) || (c == CODE_W);
	endfunction

	// Base i of a packed site pattern; bases past bit 31 read as A.
	function automatic logic [1:0] site_base(input logic [31:0] pat, input int i);
		logic [63:0] ext;
		ext = {32'd0, pat};
		return ext[2*i +: 2];
	endfunction

endpackage

// ===== hw/rtl/gcrf_if.sv =====
// ----------------------------------------------------------------------------
// gcrf channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface gcrf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  base_char;
	logic [28:0] probe_start;
	logic [28:0] probe_end;

	modport source(output valid, kind, base_char, probe_start, probe_end, input ready);
	modport sink(input valid, kind, base_char, probe_start, probe_end, output ready);
endinterface

interface gcrf_rsp_if;
	logic        valid;
	logic        ready;
	logic [16:0] gc_probe;
	logic        gc_probe_valid;
	logic [16:0] gc_near;
	logic        gc_near_valid;
	logic [16:0] gc_wide;
	logic        gc_wide_valid;
	logic [16:0] gc_frag;
	logic        gc_frag_valid;
	logic [28:0] frag_size;
	logic        range_error;

	modport source(output valid, gc_probe, gc_probe_valid, gc_near, gc_near_valid,
		gc_wide, gc_wide_valid, gc_frag, gc_frag_valid, frag_size, range_error,
		input ready);
	modport sink(input valid, gc_probe, gc_probe_valid, gc_near, gc_near_valid,
		gc_wide, gc_wide_valid, gc_frag, gc_frag_valid, frag_size, range_error,
		output ready);
endinterface

// ===== hw/rtl/gcrf_div.sv =====
// ----------------------------------------------------------------------------
// gcrf_div
// Restoring divider giving floor(num * 2^16 / den), one bit per cycle.
// ----------------------------------------------------------------------------
module gcrf_div #(
	parameter int unsigned CW = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] num,
	input  logic [CW-1:0] den,
	output logic          done,
	output logic [16:0]   quot
);
	localparam int unsigned NW = CW + 16;
	localparam int unsigned KW = $clog2(NW);

	logic [NW-1:0] num_q;
	logic [CW-1:0] den_q;
	logic [CW-1:0] rem_q;
	logic [16:0]   quot_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [CW:0]   trial;
	logic          take;

	// The remainder stays below the divisor, so the trial fits CW+1 bits.
	assign trial = {rem_q, num_q[NW-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q  <= {num, 16'd0};
				den_q  <= den;
				rem_q  <= '0;
				quot_q <= '0;
				cnt_q  <= KW'(NW - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= take ? CW'(trial - {1'b0, den_q}) : trial[CW-1:0];
				quot_q <= {quot_q[15:0], take};
				num_q  <= {num_q[NW-2:0], 1'b0};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/gc_content_and_restriction_fragment.sv =====
// ----------------------------------------------------------------------------
// gc_content_and_restriction_fragment
// Windowed GC content and restriction fragment analysis over a stored chromosome.
// ----------------------------------------------------------------------------
// Usage. Request words arrive on req: kind 0 loads one sequence byte, kind 2
// starts a new chromosome, kind 1 is a probe query. Only probe queries give a
// result word on rsp. Configuration is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce. A query walks the base memory one base per
// cycle: the union of the three windows, then the forward crawl from the
// midpoint to the next site (plus MAX_SITE_BASES - 1 bases of lookahead), the
// backward crawl likewise, and the fragment. Up to four divisions follow, one
// per fraction and skipped where its denominator is zero; the work is serial,
// set by the single read port of the base memory and the shared divider.
// Range errors skip the walk and go straight to the output state.
// Reset clears the loaded length and the configuration to its defaults; the
// base memory holds no reset state. A stalled receiver holds the result in
// the output register; loads still go on, and a further query finishes its
// walk and then waits for the output register to free up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gc_content_and_restriction_fragment #(
	parameter int unsigned MAX_BASES      = gcrf_pkg::MAX_BASES_DEF,
	parameter int unsigned MAX_SITE_BASES = gcrf_pkg::MAX_SITE_BASES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  gcrf_pkg::reg_idx_t cfg_index,
	input  logic [31:0]       cfg_data,
	gcrf_req_if.sink          req,
	gcrf_rsp_if.source        rsp
);
	import gcrf_pkg::*;

	localparam int unsigned LW = $clog2(MAX_BASES + 1);
	localparam int unsigned AW = $clog2(MAX_BASES);
	localparam int unsigned PW = ((LW > 29) ? LW : 29) + 2;
	localparam int unsigned S  = MAX_SITE_BASES;

	typedef enum logic [2:0] {
		ST_IDLE, ST_WIN, ST_FWD, ST_BWD, ST_FSET, ST_FRAG, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [28:0] near_q, wide_q;
	logic [31:0] pat_a_q, pat_b_q;
	logic [4:0]  len_a_q, cut_a_q, len_b_q, cut_b_q;

	// The base memory: one 4-bit code per stored base.
	logic [3:0]  mem [MAX_BASES];
	logic [3:0]  rd_data_s1;
	logic [LW-1:0] len_q;

	// Scan engine.
	logic [PW-1:0] rd_pos_q, rd_last_q, pos_s1;
	logic          rd_dir_q, rd_act_q, vld_s1, rd_en;
	logic [PW-1:0] rd_pos_m1;

	// Query state.
	logic [PW-1:0] mid_q, left_q, right_q, size_q;
	logic [PW-1:0] w_lo_q [3];
	logic [PW-1:0] w_hi_q [3];
	logic [LW-1:0] gc_q [4];
	logic [LW-1:0] at_q [4];
	logic [3:0]    hist_q [S];
	logic          err_q;
	logic [16:0]   frac_q [4];
	logic          fv_q [4];
	logic [1:0]    div_idx_q;
	logic          div_wait_q;

	// Output register.
	logic          ov_q;
	logic [16:0]   o_frac_q [4];
	logic          o_fv_q [4];
	logic [28:0]   o_size_q;
	logic          o_err_q;

	// Divider link.
	logic          div_start, div_done;
	logic [16:0]   div_quot;
	logic [LW-1:0] div_den;

	// ------------------------------------------------------------------
	// Request decode and window setup.
	// ------------------------------------------------------------------
	logic [3:0]    in_code;
	logic [PW-1:0] ps_x, pe_x, len_x;
	logic          bad_probe;
	logic [PW-1:0] n_lo [3];
	logic [PW-1:0] n_hi [3];
	logic [PW-1:0] u_lo, u_hi;

	function automatic logic [PW-1:0] widen_lo(input logic [PW-1:0] p, input logic [PW-1:0] m);
		return (p > m) ? p - m : PW'(1);
	endfunction

	function automatic logic [PW-1:0] widen_hi(input logic [PW-1:0] p, input logic [PW-1:0] m,
		input logic [PW-1:0] l);
		logic [PW-1:0] s;
		s = p + m;
		return (s > l) ? l : s;
	endfunction

	always_comb begin
		in_code   = char_code(req.base_char);
		ps_x      = PW'(req.probe_start);
		pe_x      = PW'(req.probe_end);
		len_x     = PW'(len_q);
		bad_probe = (ps_x == '0) || (ps_x > pe_x) || (pe_x > len_x);
		n_lo[0]   = ps_x;
		n_hi[0]   = pe_x;
		n_lo[1]   = widen_lo(ps_x, PW'(near_q));
		n_hi[1]   = widen_hi(pe_x, PW'(near_q), len_x);
		n_lo[2]   = widen_lo(ps_x, PW'(wide_q));
		n_hi[2]   = widen_hi(pe_x, PW'(wide_q), len_x);
		u_lo      = (n_lo[1] < n_lo[2]) ? n_lo[1] : n_lo[2];
		u_hi      = (n_hi[1] > n_hi[2]) ? n_hi[1] : n_hi[2];
	end

	// ------------------------------------------------------------------
	// Effective site parameters.
	// ------------------------------------------------------------------
	logic [5:0] la_e, lb_e, ca_e, cb_e;

	function automatic logic [5:0] eff_len(input logic [4:0] l);
		logic [5:0] x;
		x = {1'b0, l};
		if (x == 6'd0)
			return 6'd1;
		else if (x > 6'(S))
			return 6'(S);
		else
			return x;
	endfunction

	always_comb begin
		la_e = eff_len(len_a_q);
		lb_e = eff_len(len_b_q);
		ca_e = ({1'b0, cut_a_q} > la_e) ? la_e : {1'b0, cut_a_q};
		cb_e = ({1'b0, cut_b_q} > lb_e) ? lb_e : {1'b0, cut_b_q};
	end

	// ------------------------------------------------------------------
	// Memory access and crawl match.
	// ------------------------------------------------------------------
	logic [3:0]    code_s1;
	logic [3:0]    hist_n [S];
	logic [PW-1:0] cand;
	logic          test_n, ma, mb, ok_a, ok_b, hit;
	logic          scan_done;

	assign rd_en     = rd_act_q;
	assign rd_pos_m1 = rd_pos_q - 1'b1;
	assign scan_done = !rd_act_q && !vld_s1;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid && req.kind == KIND_LOAD &&
			in_code != CODE_NONE && len_q < LW'(MAX_BASES))
			mem[len_q[AW-1:0]] <= in_code;
		if (rd_en)
			rd_data_s1 <= mem[rd_pos_m1[AW-1:0]];
	end

	always_comb begin
		// Positions past the loaded length never take part in a match.
		code_s1 = (pos_s1 > len_x) ? CODE_NONE : rd_data_s1;
		for (int i = 0; i < S; i++) begin
			if (state_q == ST_FWD)
				hist_n[i] = (i == S - 1) ? code_s1 : hist_q[(i + 1) % S];
			else
				hist_n[i] = (i == 0) ? code_s1 : hist_q[(i + S - 1) % S];
		end
		if (state_q == ST_FWD) begin
			cand   = pos_s1 - PW'(S - 1);
			test_n = vld_s1 && (pos_s1 >= mid_q + PW'(S));
		end else begin
			cand   = pos_s1;
			test_n = vld_s1 && (pos_s1 <= mid_q);
		end
		ok_a = 1'b1;
		ok_b = 1'b1;
		for (int i = 0; i < S; i++) begin
			if (6'(i) < la_e && hist_n[i] != {2'b00, site_base(pat_a_q, i)})
				ok_a = 1'b0;
			if (6'(i) < lb_e && hist_n[i] != {2'b00, site_base(pat_b_q, i)})
				ok_b = 1'b0;
		end
		ma  = ok_a && (cand + PW'(la_e) - 1'b1 <= len_x);
		mb  = ok_b && (cand + PW'(lb_e) - 1'b1 <= len_x);
		hit = test_n && (ma || mb) &&
			((state_q == ST_FWD) || (state_q == ST_BWD));
	end

	// Fragment bounds once both crawls have ended.
	logic [PW-1:0] f_lo, f_hi;
	always_comb begin
		f_lo = (left_q == '0) ? PW'(1) : left_q;
		f_hi = (right_q > len_x) ? len_x : right_q;
	end

	assign div_den   = LW'(gc_q[div_idx_q] + at_q[div_idx_q]);
	assign div_start = (state_q == ST_DIV) && !div_wait_q && (div_den != '0);

	gcrf_div #(.CW(LW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (gc_q[div_idx_q]),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			near_q     <= 29'(NEAR_RESET);
			wide_q     <= 29'(WIDE_RESET);
			pat_a_q    <= '0;
			pat_b_q    <= '0;
			len_a_q    <= 5'd1;
			len_b_q    <= 5'd1;
			cut_a_q    <= '0;
			cut_b_q    <= '0;
			len_q      <= '0;
			rd_pos_q   <= '0;
			rd_last_q  <= '0;
			rd_dir_q   <= 1'b1;
			rd_act_q   <= 1'b0;
			vld_s1     <= 1'b0;
			pos_s1     <= '0;
			mid_q      <= '0;
			left_q     <= '0;
			right_q    <= '0;
			size_q     <= '0;
			err_q      <= 1'b0;
			div_idx_q  <= '0;
			div_wait_q <= 1'b0;
			ov_q       <= 1'b0;
			o_size_q   <= '0;
			o_err_q    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				w_lo_q[i] <= '0;
				w_hi_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				gc_q[i]     <= '0;
				at_q[i]     <= '0;
				frac_q[i]   <= '0;
				fv_q[i]     <= 1'b0;
				o_frac_q[i] <= '0;
				o_fv_q[i]   <= 1'b0;
			end
			for (int i = 0; i < S; i++)
				hist_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_NEAR_WINDOW: near_q  <= cfg_data[28:0];
					REG_WIDE_WINDOW: wide_q  <= cfg_data[28:0];
					REG_A_PATTERN:   pat_a_q <= cfg_data;
					REG_A_LENGTH:    len_a_q <= cfg_data[4:0];
					REG_A_CUT:       cut_a_q <= cfg_data[4:0];
					REG_B_PATTERN:   pat_b_q <= cfg_data;
					REG_B_LENGTH:    len_b_q <= cfg_data[4:0];
					REG_B_CUT:       cut_b_q <= cfg_data[4:0];
				endcase
			end

			vld_s1 <= rd_en;
			pos_s1 <= rd_pos_q;
			if (rd_en) begin
				if (rd_pos_q == rd_last_q)
					rd_act_q <= 1'b0;
				else
					rd_pos_q <= rd_dir_q ? rd_pos_q + 1'b1 : rd_pos_q - 1'b1;
			end

			if (ov_q && rsp.ready)
				ov_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						unique case (req.kind)
							KIND_LOAD: begin
								if (in_code != CODE_NONE && len_q < LW'(MAX_BASES))
									len_q <= len_q + 1'b1;
							end
							KIND_NEW: len_q <= '0;
							KIND_PROBE: begin
								size_q <= '0;
								for (int i = 0; i < 4; i++) begin
									frac_q[i] <= '0;
									fv_q[i]   <= 1'b0;
									gc_q[i]   <= '0;
									at_q[i]   <= '0;
								end
								if (bad_probe) begin
									err_q   <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									err_q     <= 1'b0;
									mid_q     <= (ps_x + pe_x) >> 1;
									for (int i = 0; i < 3; i++) begin
										w_lo_q[i] <= n_lo[i];
										w_hi_q[i] <= n_hi[i];
									end
									rd_pos_q  <= u_lo;
									rd_last_q <= u_hi;
									rd_dir_q  <= 1'b1;
									rd_act_q  <= 1'b1;
									state_q   <= ST_WIN;
								end
							end
							KIND_UNUSED: ;
						endcase
					end
				end

				ST_WIN: begin
					if (vld_s1) begin
						for (int i = 0; i < 3; i++) begin
							if (pos_s1 >= w_lo_q[i] && pos_s1 <= w_hi_q[i]) begin
								if (is_gc(code_s1))
									gc_q[i] <= gc_q[i] + 1'b1;
								else if (is_at(code_s1))
									at_q[i] <= at_q[i] + 1'b1;
							end
						end
					end
					if (scan_done) begin
						rd_pos_q  <= mid_q + 1'b1;
						rd_last_q <= len_x + PW'(S - 1);
						rd_dir_q  <= 1'b1;
						rd_act_q  <= 1'b1;
						right_q   <= len_x + 1'b1;
						state_q   <= ST_FWD;
					end
				end

				ST_FWD, ST_BWD: begin
					if (vld_s1) begin
						for (int i = 0; i < S; i++)
							hist_q[i] <= hist_n[i];
					end
					if (hit || scan_done) begin
						if (state_q == ST_FWD) begin
							if (hit)
								right_q <= cand + PW'(ma ? ca_e : cb_e) - 1'b1;
							// Backward crawl primes S-1 bases above the midpoint.
							rd_pos_q  <= mid_q + PW'(S - 1);
							rd_last_q <= PW'(1);
							rd_dir_q  <= 1'b0;
							rd_act_q  <= 1'b1;
							vld_s1    <= 1'b0;
							left_q    <= '0;
							state_q   <= ST_BWD;
						end else begin
							if (hit)
								left_q <= cand + PW'(ma ? ca_e : cb_e);
							rd_act_q <= 1'b0;
							vld_s1   <= 1'b0;
							state_q  <= ST_FSET;
						end
					end
				end

				ST_FSET: begin
					size_q <= (right_q + 1'b1 < left_q) ? '0 : right_q + 1'b1 - left_q;
					if (f_lo > f_hi) begin
						div_idx_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						rd_pos_q  <= f_lo;
						rd_last_q <= f_hi;
						rd_dir_q  <= 1'b1;
						rd_act_q  <= 1'b1;
						state_q   <= ST_FRAG;
					end
				end

				ST_FRAG: begin
					if (vld_s1) begin
						if (is_gc(code_s1))
							gc_q[3] <= gc_q[3] + 1'b1;
						else if (is_at(code_s1))
							at_q[3] <= at_q[3] + 1'b1;
					end
					if (scan_done) begin
						div_idx_q <= '0;
						state_q   <= ST_DIV;
					end
				end

				ST_DIV: begin
					if (!div_wait_q) begin
						if (div_den == '0) begin
							frac_q[div_idx_q] <= '0;
							fv_q[div_idx_q]   <= 1'b0;
							if (div_idx_q == 2'd3)
								state_q <= ST_OUT;
							else
								div_idx_q <= div_idx_q + 1'b1;
						end else begin
							div_wait_q <= 1'b1;
						end
					end else if (div_done) begin
						frac_q[div_idx_q] <= div_quot;
						fv_q[div_idx_q]   <= 1'b1;
						div_wait_q        <= 1'b0;
						if (div_idx_q == 2'd3)
							state_q <= ST_OUT;
						else
							div_idx_q <= div_idx_q + 1'b1;
					end
				end

				ST_OUT: begin
					if (!ov_q || rsp.ready) begin
						for (int i = 0; i < 4; i++) begin
							o_frac_q[i] <= frac_q[i];
							o_fv_q[i]   <= fv_q[i];
						end
						o_size_q <= size_q[28:0];
						o_err_q  <= err_q;
						ov_q     <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = ov_q;
	assign rsp.gc_probe       = o_frac_q[0];
	assign rsp.gc_probe_valid = o_fv_q[0];
	assign rsp.gc_near        = o_frac_q[1];
	assign rsp.gc_near_valid  = o_fv_q[1];
	assign rsp.gc_wide        = o_frac_q[2];
	assign rsp.gc_wide_valid  = o_fv_q[2];
	assign rsp.gc_frag        = o_frac_q[3];
	assign rsp.gc_frag_valid  = o_fv_q[3];
	assign rsp.frag_size      = o_size_q;
	assign rsp.range_error    = o_err_q;

	logic in_scan;
	assign in_scan = (state_q == ST_WIN) || (state_q == ST_FWD) ||
		(state_q == ST_BWD) || (state_q == ST_FRAG);

	// The loaded length never passes the memory depth.
	`GCRF_ASSERT_ALWAYS(a_len_bound, clk, (len_q <= LW'(MAX_BASES)), "length beyond memory depth")
	// Memory reads happen only while a scan phase runs.
	`GCRF_ASSERT_RST(a_rd_in_scan, clk, arst_n, rd_en |-> in_scan, "read outside a scan phase")
	// A new result word is loaded only from the output state.
	`GCRF_ASSERT_RST(a_out_load, clk, arst_n, $rose(ov_q) |-> ($past(state_q) == ST_OUT), "result loaded outside output state")
	// The divider reports only while the sequencer waits for it.
	`GCRF_ASSERT_RST(a_div_done, clk, arst_n, div_done |-> (state_q == ST_DIV && div_wait_q), "unexpected divider completion")

endmodule
